>>> hdl/pte4_pkg.sv
// shared types and constants of the four-level page table engine
// item structs, request and status codes, control and datapath command/status
`default_nettype none

package pte4_pkg;

    localparam int unsigned IDX_W   = 9;
    localparam int unsigned LINES   = 512;
    localparam int unsigned VA_W    = 48;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned OFS_W   = 12;

    localparam logic [ENTRY_W-1:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [OFS_W-1:0]   LINK_BITS  = 12'h007;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_UNMAP = 2'd1,
        REQ_XLATE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTPRES = 2'd1,
        ST_NOROOM  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VA_W-1:0]    lin_addr;
        logic [PA_W-1:0]    frame_addr;
        logic [ENTRY_W-1:0] flags;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [PA_W-1:0]    phys_result;
        logic [ENTRY_W-1:0] entry_value;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    step;
        logic    alloc;
        logic    clr_wr;
        logic    link_wr;
        logic    leaf_wr;
        logic    post;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic child_ok;
        logic room;
        logic lvl_last;
        logic lvl_done;
        logic clr_last;
        logic leaf_present;
        logic out_free;
        t_req req;
    } t_sts;

    // table index of a level: root, second, third, leaf
    function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd0:    r = va[47:39];
            2'd1:    r = va[38:30];
            2'd2:    r = va[29:21];
            default: r = va[20:12];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pte4_ctrl.sv
// controller of the page table engine: walk, allocate, clear and respond sequence
// uses pte4_pkg; drives the datapath by t_cmd and watches t_sts
`default_nettype none

module pte4_ctrl
    import pte4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_WALK    = 10'b00_0000_0100,
        S_WCHK    = 10'b00_0000_1000,
        S_ALLOC   = 10'b00_0001_0000,
        S_CLR     = 10'b00_0010_0000,
        S_LINK    = 10'b00_0100_0000,
        S_LEAF_WR = 10'b00_1000_0000,
        S_LEAF    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_INIT: begin
                // root table cleared after reset
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.lvl_done && (i_sts.req inside {REQ_MAP, REQ_UNMAP})) begin
                    n_state = S_LEAF_WR;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = i_sts.lvl_done ? S_LEAF : S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_sts.child_ok) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_WALK;
                end else if (i_sts.req != REQ_MAP) begin
                    n_code  = ST_NOTPRES;
                    n_state = S_DONE;
                end else if (i_sts.room) begin
                    n_state = S_ALLOC;
                end else begin
                    n_code  = ST_NOROOM;
                    n_state = S_DONE;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.link_wr = 1'b1;
                n_state       = i_sts.lvl_last ? S_LEAF_WR : S_ALLOC;
            end
            S_LEAF_WR: begin
                o_cmd.leaf_wr = 1'b1;
                n_code        = ST_OK;
                n_state       = S_DONE;
            end
            S_LEAF: begin
                if (i_sts.req == REQ_XLATE && !i_sts.leaf_present) begin
                    n_code = ST_NOTPRES;
                end else begin
                    n_code = ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/pte4_dp.sv
// datapath of the page table engine: table memory, walk pointer, allocator, result register
// uses pte4_pkg; commanded by pte4_ctrl
`default_nettype none

module pte4_dp
    import pte4_pkg::*;
#(
    parameter int unsigned NUM_TABLES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    output t_sts          o_sts,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    localparam int unsigned TW    = $clog2(NUM_TABLES);
    localparam int unsigned NW    = $clog2(NUM_TABLES + 1);
    localparam int unsigned AW    = TW + IDX_W;
    localparam int unsigned DEPTH = NUM_TABLES * LINES;

    logic [ENTRY_W-1:0] mem [DEPTH];

    t_in_item           r_req;
    logic [ENTRY_W-1:0] r_rdata;
    logic [TW-1:0]      r_tbl;
    logic [1:0]         r_lvl;
    logic [NW-1:0]      r_next;
    logic [TW-1:0]      r_new;
    logic [IDX_W-1:0]   r_clr;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [AW-1:0]      walk_addr;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;
    logic [1:0]         need;
    logic [NW-1:0]      free_cnt;
    logic [39:0]        child_full;
    t_out_item          res;

    assign walk_addr  = {r_tbl, idx_of(r_req.lin_addr, r_lvl)};
    assign child_full = r_rdata[51:12];

    always_comb begin
        we    = i_cmd.clr_wr | i_cmd.link_wr | i_cmd.leaf_wr;
        waddr = walk_addr;
        wdata = '0;
        if (i_cmd.clr_wr) begin
            waddr = {r_new, r_clr};
        end else if (i_cmd.link_wr) begin
            wdata = {{(ENTRY_W - OFS_W - TW){1'b0}}, r_new, LINK_BITS};
        end else if (t_req'(r_req.req_type) == REQ_MAP) begin
            wdata = {{(ENTRY_W - PA_W){1'b0}}, r_req.frame_addr} | r_req.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[walk_addr];
        end
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
        if (i_cmd.post) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl       <= '0;
            r_lvl       <= '0;
            r_next      <= NW'(1);
            r_new       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_tbl <= '0;
                r_lvl <= '0;
            end else if (i_cmd.step) begin
                r_tbl <= r_rdata[12 +: TW];
                r_lvl <= r_lvl + 2'd1;
            end else if (i_cmd.link_wr) begin
                r_tbl <= r_new;
                r_lvl <= r_lvl + 2'd1;
            end
            if (i_cmd.alloc) begin
                r_new  <= r_next[TW-1:0];
                r_next <= r_next + NW'(1);
                r_clr  <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tables the map still lacks against tables left
    assign need     = 2'd3 - r_lvl;
    assign free_cnt = NW'(NUM_TABLES) - r_next;

    always_comb begin
        res             = '0;
        res.status      = i_cmd.code;
        if (i_cmd.code == ST_OK && t_req'(r_req.req_type) == REQ_XLATE) begin
            res.phys_result = r_rdata[PA_W-1:0] & FRAME_MASK[PA_W-1:0]
                            | {{(PA_W - OFS_W){1'b0}}, r_req.lin_addr[OFS_W-1:0]};
        end
        if (i_cmd.code == ST_OK && t_req'(r_req.req_type) == REQ_READ) begin
            res.entry_value = r_rdata;
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.child_ok     = r_rdata[0] && (child_full < 40'(NUM_TABLES));
        o_sts.room         = ({{(NW - 2){1'b0}}, need} <= free_cnt);
        o_sts.lvl_last     = (r_lvl == 2'd2);
        o_sts.lvl_done     = (r_lvl == 2'd3);
        o_sts.clr_last     = (r_clr == IDX_W'(LINES - 1));
        o_sts.leaf_present = r_rdata[0];
        o_sts.out_free     = !r_out_valid || !i_out_stall;
        o_sts.req          = t_req'(r_req.req_type);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

>>> hdl/four_level_page_table_engine_unit.sv
// four-level page table engine, one item in flight, input stalled while it is worked
// after reset the root table is cleared entry by entry with the input stalled
// a missing path or a refused map answers without touching the leaf, and no table is written
// a map that allocates tables clears each new table entry by entry
// result register frees the engine while a result is stalled; sync active-low reset
`default_nettype none

module four_level_page_table_engine_unit
    import pte4_pkg::*;
#(
    parameter int unsigned NUM_TABLES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_cmd cmd;
    t_sts sts;

    pte4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    pte4_dp #(
        .NUM_TABLES (NUM_TABLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_four_level_page_table_engine_unit.sv
// self-checking bench for the four-level page table engine: map, unmap, translate and read
// items are checked against a page walk predictor kept here; uses pte4_pkg and the engine rtl
module tb_four_level_page_table_engine_unit
    import pte4_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_TABLES = 64;
    localparam logic [11:0] PTR_LINK = 12'h007;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    four_level_page_table_engine_unit #(
        .NUM_TABLES(N_TABLES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // predictor copy of the page tables
    logic [63:0] page_mem [N_TABLES * LINES];
    int unsigned next_tbl;

    t_in_item  pending_items[$];
    t_out_item walk_results_due[$];
    t_out_item due;

    logic [8:0] top_pool [2];
    logic [8:0] mid_pool [2];
    logic [8:0] low_pool [3];
    logic [8:0] slot_pool [6];

    int   total_items = 0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   tx_gap = 0;
    int   tx_idle_pct = 0;
    int   rx_wait = 0;
    int   rx_idle_pct = 0;
    int   rx_cycles = 0;
    logic hold_out = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [8:0] level_slot(input logic [47:0] va, input int lvl);
        return va[39 - 9 * lvl +: 9];
    endfunction

    // walks the tables, applies map/unmap and returns the result the engine owes
    function automatic t_out_item page_walk_result(input t_in_item it);
        t_out_item   res;
        logic [63:0] ent;
        int unsigned tbl;
        int unsigned got;
        int unsigned nt;
        bit          walking;
        res = '0;
        res.status = ST_OK;
        tbl = 0;
        got = 0;
        walking = 1'b1;
        for (int lvl = 0; lvl < 3; lvl++) begin
            if (walking) begin
                ent = page_mem[tbl * LINES + level_slot(it.lin_addr, lvl)];
                if (ent[0] && ent[51:12] < N_TABLES) begin
                    tbl = 32'(ent[51:12]);
                    got++;
                end else begin
                    walking = 1'b0;
                end
            end
        end
        if (it.req_type == REQ_MAP) begin
            if (next_tbl > N_TABLES || (3 - got) > N_TABLES - next_tbl) begin
                res.status = ST_NOROOM;
            end else begin
                for (int lvl = got; lvl < 3; lvl++) begin
                    nt = next_tbl;
                    next_tbl++;
                    for (int k = 0; k < LINES; k++) page_mem[nt * LINES + k] = '0;
                    page_mem[tbl * LINES + level_slot(it.lin_addr, lvl)] =
                        (64'(nt) << 12) | 64'(PTR_LINK);
                    tbl = nt;
                end
                page_mem[tbl * LINES + level_slot(it.lin_addr, 3)] =
                    {12'b0, it.frame_addr} | it.flags;
            end
        end else if (got < 3) begin
            res.status = ST_NOTPRES;
        end else begin
            ent = page_mem[tbl * LINES + level_slot(it.lin_addr, 3)];
            case (it.req_type)
                REQ_UNMAP: begin
                    page_mem[tbl * LINES + level_slot(it.lin_addr, 3)] = '0;
                end
                REQ_XLATE: begin
                    if (!ent[0]) res.status = ST_NOTPRES;
                    else res.phys_result = {ent[51:12], it.lin_addr[11:0]};
                end
                default: begin
                    res.entry_value = ent;
                end
            endcase
        end
        return res;
    endfunction

    function automatic t_in_item mk_item(input t_req rq, input logic [47:0] va,
                                         input logic [51:0] pa, input logic [63:0] fl);
        t_in_item it;
        it.req_type = rq;
        it.lin_addr = va;
        it.frame_addr = pa;
        it.flags = fl;
        return it;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    task automatic queue_random_items(input int count);
        t_in_item it;
        int       r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            it.req_type = r < 30 ? REQ_MAP : r < 40 ? REQ_UNMAP : r < 72 ? REQ_XLATE : REQ_READ;
            it.lin_addr = 48'({$urandom, $urandom});
            // keep most addresses on a few shared paths so maps and lookups meet
            if ($urandom_range(0, 99) < 85 ||
                    (it.req_type == REQ_MAP && $urandom_range(0, 1) == 1)) begin
                it.lin_addr[47:12] = {top_pool[$urandom_range(0, 1)],
                                      mid_pool[$urandom_range(0, 1)],
                                      low_pool[$urandom_range(0, 2)],
                                      slot_pool[$urandom_range(0, 5)]};
            end
            it.frame_addr = 52'({$urandom, $urandom});
            if ($urandom_range(0, 99) < 70) it.frame_addr[11:0] = '0;
            it.flags = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 60) begin
                it.flags[63:12] = '0;
                it.flags[0] = ($urandom_range(0, 9) != 0);
            end
            pending_items.push_back(it);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch on result %0d, %s: got %h, expected %h",
                 results_seen, what, got, want);
    endtask

    initial begin : stimulus
        for (int k = 0; k < N_TABLES * LINES; k++) page_mem[k] = '0;
        next_tbl = 1;

        top_pool[0] = '0;
        top_pool[1] = 9'($urandom);
        mid_pool[0] = '0;
        mid_pool[1] = 9'($urandom);
        for (int k = 0; k < 3; k++) low_pool[k] = 9'($urandom);
        slot_pool[0] = '0;
        slot_pool[1] = 9'h1FF;
        for (int k = 2; k < 6; k++) slot_pool[k] = 9'($urandom);

        // empty tables
        pending_items.push_back(mk_item(REQ_READ,  48'h0, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h0, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_UNMAP, 48'h0, 52'h0, 64'h0));
        // full path allocation, then lookups
        pending_items.push_back(mk_item(REQ_MAP, 48'h0abc, 52'h0_0000_1234_5000, 64'h3));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h0fff, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_READ, 48'h0, 52'h0, 64'h0));
        // overwrite of an existing leaf with all ones
        pending_items.push_back(mk_item(REQ_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF, '1));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h07ff, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_MAP, 48'hFFFF_FFFF_FFFF, 52'h0,
                                        64'h8000_0000_0000_0001));
        pending_items.push_back(mk_item(REQ_XLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0));
        // path exists but leaf empty
        pending_items.push_back(mk_item(REQ_READ, 48'h1000, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h1000, 52'h0, 64'h0));
        // leaf written without its present bit
        pending_items.push_back(mk_item(REQ_MAP, 48'h2000, 52'h0_0000_0000_5000, 64'h2));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h2000, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_READ, 48'h2000, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_UNMAP, 48'h0, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_XLATE, 48'h0, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_UNMAP, 48'h0, 52'h0, 64'h0));
        // partial paths: two new tables, then one
        pending_items.push_back(mk_item(REQ_MAP, 48'h0000_4000_0000, 52'h0_00AB_C000, 64'h1));
        pending_items.push_back(mk_item(REQ_MAP, 48'h0000_0020_0000, 52'h0_00DE_F000, 64'h7));
        pending_items.push_back(mk_item(REQ_READ, 48'h0000_8000_0000, 52'h0, 64'h0));
        pending_items.push_back(mk_item(REQ_UNMAP, 48'h0080_0000_0000, 52'h0, 64'h0));

        queue_random_items(780);
        // fresh top-level paths until the table pool runs dry
        for (int n = 0; n < 22; n++)
            pending_items.push_back(mk_item(REQ_MAP, 48'({$urandom, $urandom}),
                                            52'({$urandom, $urandom}), {$urandom, $urandom}));
        queue_random_items(780);
        total_items = pending_items.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items || walk_results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    // long receiver hold-off so the engine backs up into its input
    initial begin
        while (items_taken < 400) @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin : tx_side
        logic     v;
        t_in_item it;
        int       g;
        v = in_valid;
        it = in_item;
        g = tx_gap;
        if (!i_rst_n) begin
            v = 1'b0;
        end else begin
            if (v && !o_in_stall) begin
                walk_results_due.push_back(page_walk_result(it));
                items_taken++;
                v = 1'b0;
                if (items_taken % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       tx_idle_pct = 0;
                        1:       tx_idle_pct = 30;
                        default: tx_idle_pct = 70;
                    endcase
                end
                g = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
            end
            if (!v) begin
                if (g > 0) begin
                    g--;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    v = 1'b1;
                end
            end
        end
        in_valid <= v;
        in_item <= it;
        tx_gap <= g;
    end

    always @(posedge i_clk) begin : rx_side
        rx_cycles++;
        if (rx_cycles % 256 == 0) begin
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 5;
                default: rx_idle_pct = 20;
            endcase
        end
        if (rx_wait == 0 && $urandom_range(0, 99) < rx_idle_pct) rx_wait = pick_gap();
        i_out_stall <= hold_out || (rx_wait > 0);
        if (rx_wait > 0) rx_wait--;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (walk_results_due.size() == 0) begin
                report_mismatch("result with nothing due", 64'(o_out_item.status), 64'h0);
            end else begin
                due = walk_results_due.pop_front();
                if (o_out_item.status !== due.status)
                    report_mismatch("status", 64'(o_out_item.status), 64'(due.status));
                if (o_out_item.phys_result !== due.phys_result)
                    report_mismatch("phys_result", 64'(o_out_item.phys_result),
                                    64'(due.phys_result));
                if (o_out_item.entry_value !== due.entry_value)
                    report_mismatch("entry_value", o_out_item.entry_value, due.entry_value);
            end
        end
    end

endmodule
